/* src/sia_pkg.sv */
`default_nettype none

package sia_pkg;

  // Field widths
  localparam int ID_W      = 8;
  localparam int ACT_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 9;
  localparam int TIME_W    = 32;
  localparam int TIMEOUT_W = 16;

  // Defaults
  localparam int                   DEF_NUM_IDS   = 256;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ALIVE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_AUTH   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SCAN   = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  // Test applied to one table entry by the shared evaluation unit
  typedef enum logic [2:0] {
    K_FREE,
    K_RECYCLE,
    K_SCAN,
    K_ALIVE,
    K_REMOVE,
    K_SETAUTH,
    K_QUERY
  } op_kind_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic              in_use;
    logic              auth;
    logic              tracked;
    logic [TIME_W-1:0] last_seen;
  } entry_t;

  // Outcome of one entry test
  typedef struct packed {
    logic   hit;
    entry_t upd;
  } eval_t;

endpackage

`default_nettype wire

/* src/sia_ram.sv */
`default_nettype none

module sia_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/sia_eval.sv */
`default_nettype none

module sia_eval
  import sia_pkg::*;
(
  input  wire op_kind_t               kind,
  input  wire entry_t                 ent,
  input  wire logic [TIME_W-1:0]      now,
  input  wire logic [TIMEOUT_W-1:0]   timeout,
  output      eval_t                  res
);

  logic [TIME_W-1:0] idle;
  logic              expired;

  // Idle time modulo 2^32, strictly over the timeout
  assign idle    = now - ent.last_seen;
  assign expired = idle > TIME_W'(timeout);

  // Test the entry and build its updated value
  always_comb begin
    res.hit = 1'b0;
    res.upd = ent;
    case (kind)
      K_FREE: begin
        res.hit         = !ent.in_use;
        res.upd.in_use  = 1'b1;
        res.upd.auth    = 1'b0;
        res.upd.tracked = 1'b0;
      end
      K_RECYCLE: begin
        res.hit         = !ent.auth;
        res.upd.in_use  = 1'b1;
        res.upd.auth    = 1'b0;
        res.upd.tracked = 1'b0;
      end
      K_SCAN: begin
        res.hit         = ent.tracked && expired;
        res.upd.in_use  = 1'b0;
        res.upd.auth    = 1'b0;
        res.upd.tracked = 1'b0;
      end
      K_ALIVE: begin
        res.hit           = ent.in_use;
        res.upd.tracked   = 1'b1;
        res.upd.last_seen = now;
      end
      K_REMOVE: begin
        res.hit         = ent.in_use;
        res.upd.in_use  = 1'b0;
        res.upd.auth    = 1'b0;
        res.upd.tracked = 1'b0;
      end
      K_SETAUTH: begin
        res.hit      = ent.in_use;
        res.upd.auth = 1'b1;
      end
      K_QUERY: begin
        res.hit = ent.in_use;
      end
      default: begin
        res.hit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/session_id_allocator_with_timeout.sv */
// Session ID table with idle timeout. Pulse start with action and id while busy is low;
// exactly one result comes back per operation, on status, result_id, exists and
// removed_count for the single cycle in which done is high, and it cannot be held off.
// All table state sits in one RAM with one read and one write per cycle, and every
// operation on it goes through a single entry-test unit. Tick and unused actions
// answer in the cycle after acceptance, as do alive, remove, authenticate and query
// with an out-of-range id. An allocate runs a next-fit search and, if that fails, a
// recycle search. After reset the block stays busy while it clears the RAM; the idle
// timeout may be written between operations, including during the clearing sweep.
`default_nettype none

module session_id_allocator_with_timeout
  import sia_pkg::*;
#(
  parameter int NUM_IDS = DEF_NUM_IDS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [ACT_W-1:0]      action,
  input  wire logic [ID_W-1:0]       id,
  input  wire logic                  cfg_we,
  input  wire logic [TIMEOUT_W-1:0]  cfg_wdata,
  output      logic                  done,
  output      logic [STATUS_W-1:0]   status,
  output      logic [ID_W-1:0]       result_id,
  output      logic                  exists,
  output      logic [CNT_W-1:0]      removed_count
);

  localparam int IW = $clog2(NUM_IDS);
  localparam int CW = $clog2(NUM_IDS + 1);
  localparam logic [IW-1:0] LAST_ID = IW'(NUM_IDS - 1);
  localparam logic [IW-1:0] TOP_M1  = IW'(NUM_IDS - 2);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_APPLY,
    S_WALK
  } state_t;

  state_t                 state;
  op_kind_t               kind;
  logic [IW-1:0]          addr;
  logic                   issue_on;
  logic                   pend;
  logic [IW-1:0]          paddr;
  logic                   plast;
  logic [IW-1:0]          last_assigned;
  logic [TIME_W-1:0]      now_ticks;
  logic [TIMEOUT_W-1:0]   idle_timeout;
  logic [CW-1:0]          cnt;

  logic [IW-1:0]          a_next;
  logic                   is_last;
  logic [IW-1:0]          fit_start;
  logic [CW-1:0]          cnt_inc;
  logic                   id_ok;

  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  entry_t                 mem_wdata;
  logic [IW-1:0]          mem_raddr;
  logic [$bits(entry_t)-1:0] mem_rdata;
  entry_t                 ent;
  eval_t                  ev;

  assign busy      = (state != S_IDLE);
  assign ent       = entry_t'(mem_rdata);
  assign id_ok     = 32'(id) < 32'(NUM_IDS);
  assign cnt_inc   = cnt + CW'(ev.hit);
  assign fit_start = (last_assigned >= TOP_M1) ? '0 : last_assigned + 1'b1;

  // Walk order: next-fit wraps below the top ID, the others count up
  always_comb begin
    case (kind)
      K_FREE: begin
        a_next  = (addr >= TOP_M1) ? '0 : addr + 1'b1;
        is_last = (a_next == last_assigned);
      end
      K_RECYCLE: begin
        a_next  = addr + 1'b1;
        is_last = (addr == TOP_M1);
      end
      default: begin
        a_next  = addr + 1'b1;
        is_last = (addr == LAST_ID);
      end
    endcase
  end

  // Drive the RAM ports
  always_comb begin
    mem_raddr = addr;
    mem_waddr = addr;
    mem_wdata = ev.upd;
    mem_we    = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_APPLY: begin
        mem_we = ev.hit && (kind != K_QUERY);
      end
      S_WALK: begin
        mem_waddr = paddr;
        mem_we    = pend && ev.hit;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  sia_ram #(
    .W     ($bits(entry_t)),
    .DEPTH (NUM_IDS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sia_eval u_eval (
    .kind    (kind),
    .ent     (ent),
    .now     (now_ticks),
    .timeout (idle_timeout),
    .res     (ev)
  );

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      kind            <= K_QUERY;
      addr            <= '0;
      issue_on        <= 1'b0;
      pend            <= 1'b0;
      plast           <= 1'b0;
      last_assigned   <= '0;
      now_ticks       <= '0;
      idle_timeout    <= TIMEOUT_RESET;
      cnt             <= '0;
      done            <= 1'b0;
      status          <= ST_OK;
      result_id       <= '0;
      exists          <= 1'b0;
      removed_count   <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        idle_timeout <= cfg_wdata;
      end
      case (state)
        // Sweep zeros through the table
        S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == LAST_ID) begin
            state <= S_IDLE;
          end
        end

        // Take a command
        S_IDLE: begin
          if (start) begin
            status        <= ST_OK;
            result_id     <= '0;
            exists        <= 1'b0;
            removed_count <= '0;
            addr          <= IW'(id);
            case (action)
              ACT_ALLOC: begin
                issue_on <= 1'b1;
                pend     <= 1'b0;
                state    <= S_WALK;
                if (fit_start == last_assigned) begin
                  kind <= K_RECYCLE;
                  addr <= IW'(1);
                end else begin
                  kind <= K_FREE;
                  addr <= fit_start;
                end
              end
              ACT_ALIVE, ACT_REMOVE, ACT_AUTH, ACT_QUERY: begin
                case (action)
                  ACT_ALIVE:  kind <= K_ALIVE;
                  ACT_REMOVE: kind <= K_REMOVE;
                  ACT_AUTH:   kind <= K_SETAUTH;
                  default:    kind <= K_QUERY;
                endcase
                if (id_ok) begin
                  state <= S_LOOK;
                end else begin
                  done <= 1'b1;
                  if (action != ACT_QUERY) begin
                    status <= ST_ABSENT;
                  end
                end
              end
              ACT_TICK: begin
                now_ticks <= now_ticks + 1'b1;
                done      <= 1'b1;
              end
              ACT_SCAN: begin
                kind     <= K_SCAN;
                addr     <= '0;
                cnt      <= '0;
                issue_on <= 1'b1;
                pend     <= 1'b0;
                state    <= S_WALK;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end

        // Wait for the entry read
        S_LOOK: begin
          state <= S_APPLY;
        end

        // Apply the single-entry operation and answer
        S_APPLY: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (kind == K_QUERY) begin
            exists <= ev.hit;
          end else if (!ev.hit) begin
            status <= ST_ABSENT;
          end
        end

        // Stream reads through the table and test each returning entry
        S_WALK: begin
          if (issue_on) begin
            pend     <= 1'b1;
            paddr    <= addr;
            plast    <= is_last;
            addr     <= a_next;
            issue_on <= !is_last;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            case (kind)
              K_FREE, K_RECYCLE: begin
                if (ev.hit) begin
                  last_assigned <= paddr;
                  result_id     <= ID_W'(paddr);
                  done          <= 1'b1;
                  state         <= S_IDLE;
                end else if (plast) begin
                  if (kind == K_FREE) begin
                    kind     <= K_RECYCLE;
                    addr     <= IW'(1);
                    issue_on <= 1'b1;
                    pend     <= 1'b0;
                  end else begin
                    status <= ST_FULL;
                    done   <= 1'b1;
                    state  <= S_IDLE;
                  end
                end
              end
              default: begin
                cnt <= cnt_inc;
                if (plast) begin
                  removed_count <= CNT_W'(cnt_inc);
                  done          <= 1'b1;
                  state         <= S_IDLE;
                end
              end
            endcase
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result beat only appears with the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // The table changes only while an operation or the clearing sweep runs
  a_write_busy: assert property (@(posedge clk) disable iff (rst) mem_we |-> busy)
    else $error("table write while idle");

  // The top ID is never handed out
  a_top_free: assert property (@(posedge clk) disable iff (rst)
    last_assigned != LAST_ID)
    else $error("top ID was allocated");

  // Once the last read of a pass is out, no further read is issued
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && pend && plast) |-> !issue_on)
    else $error("walk issued past the end of its pass");

  // Every result follows either a busy period or a command taken in the cycle before
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without a command");

endmodule

`default_nettype wire
